[sv/bmsort_pkg.sv]
package bmsort_pkg;

  localparam int MAX_ITEMS_DEF = 64;
  localparam int KEY_BITS_DEF  = 32;
  localparam int KEY_W         = 32;
  localparam int TAG_W         = 16;
  localparam int CNT_W         = 7;
  localparam int LVL_W         = 3;

  typedef struct packed {
    logic             wr_en;
    logic [CNT_W-1:0] wr_addr;
    logic             rd_en;
    logic [CNT_W-1:0] rd_addr;
    logic             scan_clr;
    logic             new_flush;
    logic             emit;
    logic             emit_empty;
    logic             last;
    logic [CNT_W-1:0] count;
    logic             dropped;
  } cmd_t;

endpackage

[sv/bmsort_ram.sv]
module bmsort_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/bmsort_ctrl.sv]
module bmsort_ctrl #(
  parameter int MAX_ITEMS = bmsort_pkg::MAX_ITEMS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_action,
  output logic              busy,
  output bmsort_pkg::cmd_t  cmd
);
  import bmsort_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_EMIT} state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] held_r, held_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] emitted_r, emitted_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    held_nxt    = held_r;
    ovf_nxt     = ovf_r;
    rd_nxt      = rd_r;
    emitted_nxt = emitted_r;
    cmd         = '0;
    cmd.wr_addr = held_r;
    cmd.rd_addr = rd_r;
    cmd.count   = held_r;
    cmd.dropped = ovf_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (!in_action) begin
            if (held_r >= CNT_W'(MAX_ITEMS)) begin
              ovf_nxt = 1'b1;
            end else begin
              cmd.wr_en = 1'b1;
              held_nxt  = held_r + 1'b1;
            end
          end else if (held_r == '0) begin
            cmd.emit_empty = 1'b1;
            ovf_nxt        = 1'b0;
          end else begin
            cmd.new_flush = 1'b1;
            rd_nxt        = '0;
            emitted_nxt   = '0;
            state_nxt     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.rd_en    = 1'b1;
        cmd.scan_clr = (rd_r == '0);
        rd_nxt       = rd_r + 1'b1;
        if (rd_r == held_r - 1'b1) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit    = 1'b1;
        cmd.last    = (emitted_r == held_r - 1'b1);
        emitted_nxt = emitted_r + 1'b1;
        rd_nxt      = '0;
        if (cmd.last) begin
          held_nxt  = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      held_r    <= '0;
      ovf_r     <= 1'b0;
      rd_r      <= '0;
      emitted_r <= '0;
    end else begin
      state_r   <= state_nxt;
      held_r    <= held_nxt;
      ovf_r     <= ovf_nxt;
      rd_r      <= rd_nxt;
      emitted_r <= emitted_nxt;
    end
  end

endmodule

[sv/bmsort_dp.sv]
module bmsort_dp #(
  parameter int MAX_ITEMS = bmsort_pkg::MAX_ITEMS_DEF,
  parameter int KEY_BITS  = bmsort_pkg::KEY_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bmsort_pkg::cmd_t             cmd,
  input  logic [bmsort_pkg::KEY_W-1:0] in_key,
  input  logic [bmsort_pkg::TAG_W-1:0] in_tag,
  output logic                         out_valid,
  output logic [bmsort_pkg::KEY_W-1:0] out_key,
  output logic [bmsort_pkg::TAG_W-1:0] out_tag,
  output logic                         out_last,
  output logic                         out_empty_res,
  output logic [bmsort_pkg::CNT_W-1:0] out_item_count,
  output logic                         out_dropped
);
  import bmsort_pkg::*;

  localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int AW = $clog2(MAX_ITEMS);
  localparam int RW = KW + LVL_W + AW;

  logic [KW+TAG_W-1:0] rd_data;
  logic                vld_r;
  logic [AW-1:0]       raddr_r;
  logic [LVL_W-1:0]    lvl;
  logic [CNT_W-1:0]    pos;
  logic [RW-1:0]       rank;
  logic                elig, better;
  logic [RW-1:0]       best_r, prev_r;
  logic                best_v_r, have_prev_r;
  logic [KW-1:0]       best_key_r;
  logic [TAG_W-1:0]    best_tag_r;

  bmsort_ram #(.WIDTH(KW + TAG_W), .DEPTH(MAX_ITEMS)) u_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (cmd.wr_addr[AW-1:0]),
    .wdata ({in_key[KW-1:0], in_tag}),
    .raddr (cmd.rd_addr[AW-1:0]),
    .rdata (rd_data)
  );

  // The run that holds an item is given by the highest bit where its
  // position differs from the count; smaller runs are more recent.
  always_comb begin
    pos = CNT_W'(raddr_r);
    lvl = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (pos[i] != cmd.count[i]) begin
        lvl = LVL_W'(i);
      end
    end
    rank   = {rd_data[KW+TAG_W-1:TAG_W], lvl, raddr_r};
    elig   = !have_prev_r || (rank > prev_r);
    better = !best_v_r || (rank < best_r);
  end

  always_ff @(posedge clk) begin
    raddr_r <= cmd.rd_addr[AW-1:0];
    if (vld_r && elig && better) begin
      best_r     <= rank;
      best_key_r <= rd_data[KW+TAG_W-1:TAG_W];
      best_tag_r <= rd_data[TAG_W-1:0];
    end
    if (cmd.emit) begin
      prev_r <= best_r;
    end
    out_key        <= cmd.emit ? KEY_W'(best_key_r) : '0;
    out_tag        <= cmd.emit ? best_tag_r : '0;
    out_last       <= cmd.last || cmd.emit_empty;
    out_empty_res  <= cmd.emit_empty;
    out_item_count <= cmd.count;
    out_dropped    <= cmd.dropped;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= 1'b0;
      best_v_r    <= 1'b0;
      have_prev_r <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      vld_r     <= cmd.rd_en;
      out_valid <= cmd.emit || cmd.emit_empty;
      if (cmd.scan_clr) begin
        best_v_r <= 1'b0;
      end else if (vld_r && elig && better) begin
        best_v_r <= 1'b1;
      end
      if (cmd.new_flush) begin
        have_prev_r <= 1'b0;
      end else if (cmd.emit) begin
        have_prev_r <= 1'b1;
      end
    end
  end

endmodule

[sv/bottom_up_merge_sorter_top.sv]
// Sorter that collects items and returns them in ascending key order.
// Input: an item is taken when start is high and busy is low. in_action 0
// adds the key and tag; adds beyond MAX_ITEMS are dropped and
// remembered. in_action 1 flushes the store.
// Output: each result is shown for one cycle with out_valid high; the
// receiver cannot stall. The last result of a flush has out_last set, and
// every result carries the held count and the dropped flag.
// An empty flush returns one result with out_empty_res set, in the cycle
// right after the flush is taken.
// A flush of n items finds each result by one scan of the item memory, one
// entry per cycle through its single read port; busy stays high for the
// whole flush. Ties order items by run, most recent run first, and then
// by arrival. After the last result the store and the dropped flag clear.
// Reset is synchronous and active low; it empties the store and clears the
// dropped flag. Memory contents are not cleared.
module bottom_up_merge_sorter_top #(
  parameter int MAX_ITEMS = bmsort_pkg::MAX_ITEMS_DEF,
  parameter int KEY_BITS  = bmsort_pkg::KEY_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_action,
  input  logic [bmsort_pkg::KEY_W-1:0] in_key,
  input  logic [bmsort_pkg::TAG_W-1:0] in_tag,
  output logic                         out_valid,
  output logic [bmsort_pkg::KEY_W-1:0] out_key,
  output logic [bmsort_pkg::TAG_W-1:0] out_tag,
  output logic                         out_last,
  output logic                         out_empty_res,
  output logic [bmsort_pkg::CNT_W-1:0] out_item_count,
  output logic                         out_dropped
);
  import bmsort_pkg::*;

  cmd_t cmd;

  bmsort_ctrl #(.MAX_ITEMS(MAX_ITEMS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .busy      (busy),
    .cmd       (cmd)
  );

  bmsort_dp #(.MAX_ITEMS(MAX_ITEMS), .KEY_BITS(KEY_BITS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_key         (in_key),
    .in_tag         (in_tag),
    .out_valid      (out_valid),
    .out_key        (out_key),
    .out_tag        (out_tag),
    .out_last       (out_last),
    .out_empty_res  (out_empty_res),
    .out_item_count (out_item_count),
    .out_dropped    (out_dropped)
  );

endmodule

[sv/bmsort_chk.sv]
module bmsort_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         in_action,
  input logic                         out_valid,
  input logic [bmsort_pkg::KEY_W-1:0] out_key,
  input logic [bmsort_pkg::TAG_W-1:0] out_tag,
  input logic                         out_last,
  input logic                         out_empty_res,
  input logic [bmsort_pkg::CNT_W-1:0] out_item_count
);

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_res |-> out_last && out_item_count == '0)
    else $error("empty result must be last with zero count");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_res |-> out_key == '0 && out_tag == '0)
    else $error("empty result must carry zero key and tag");

  a_add_silent: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_action |=> !out_valid)
    else $error("an add item produced a result");

  a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> busy)
    else $error("flush ended before its last result");

  a_count_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_empty_res |-> out_item_count != '0)
    else $error("sorted result with zero item count");

endmodule

bind bottom_up_merge_sorter_top bmsort_chk u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_action      (in_action),
  .out_valid      (out_valid),
  .out_key        (out_key),
  .out_tag        (out_tag),
  .out_last       (out_last),
  .out_empty_res  (out_empty_res),
  .out_item_count (out_item_count)
);
